// ===== hdl/ssr_pkg.sv =====
// Shared widths and constants for the subset-sum reachability core.
`timescale 1ns / 1ps
`default_nettype none
package ssr_pkg;
    localparam int ELEM_W = 16;   // element value width
    localparam int TGT_W  = 10;   // target sum register width
    localparam int CMP_W  = 17;   // common width for range compares
endpackage
`default_nettype wire

// ===== hdl/ssr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none
module ssr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/subset_sum_reachability_core.sv =====
// Top level of the subset-sum reachability core: sequencer around the bitset RAM.
//
//  Channel   | Ports                                      | Handshake
//  ----------+--------------------------------------------+----------------------------
//  input     | element_value, has_element, set_end        | start & !busy
//  result    | subset_found                               | done, one cycle, no stall
//  config    | cfg_wdata (target sum)                     | cfg_we, no wait
//
// An element v that is in range walks j from MAX_SUM down to v, one bitset
// entry per cycle through the single RAM read port (read j-v, write j next cycle).
// An out-of-range element or an item with no element skips the walk.
// A set end adds the target lookup and report, then a clearing pass over
// every entry restores the bitset to "only sum 0". Reset also runs this
// clearing pass before the first transaction is taken. busy is high throughout.
// The receiver cannot stall: done is valid for exactly one cycle; subset_found holds until the next result.
`timescale 1ns / 1ps
`default_nettype none
module subset_sum_reachability_core #(
    parameter int MAX_SUM = 1023
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ssr_pkg::TGT_W-1:0]   cfg_wdata,
    input  wire logic                        start,
    input  wire logic [ssr_pkg::ELEM_W-1:0]  element_value,
    input  wire logic                        has_element,
    input  wire logic                        set_end,
    output logic                             busy,
    output logic                             done,
    output logic                             subset_found
);
    import ssr_pkg::*;

    localparam int DEPTH  = MAX_SUM + 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] MAX_A = ADDR_W'(MAX_SUM);
    localparam logic [CMP_W-1:0]  MAX_C = CMP_W'(MAX_SUM);

    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep: entry 0 <- 1, others <- 0
        ST_IDLE,
        ST_WALK,    // read j-v, j counts down to v
        ST_DRAIN,   // last write of the walk lands
        ST_LOOKUP,  // read target entry
        ST_REPORT   // RAM data valid, emit result
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] v_reg, v_next;
    logic [TGT_W-1:0]  tgt_reg, tgt_next;
    logic [TGT_W-1:0]  cfg_tgt_reg, cfg_tgt_next;
    logic              last_reg, last_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    logic              accept;
    logic [CMP_W-1:0]  elem_c;
    logic              elem_skip;
    logic              tgt_ok;
    logic [ADDR_W-1:0] tgt_addr;
    logic [CMP_W-1:0]  tgt_c;

    ssr_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_bits (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);

    // Element is a no-op when zero, above the bound or above the target.
    assign elem_c    = CMP_W'(element_value);
    assign elem_skip = (element_value == '0) || (elem_c > MAX_C)
                       || (elem_c > CMP_W'(cfg_tgt_reg));

    assign tgt_c    = CMP_W'(tgt_reg);
    assign tgt_ok   = (tgt_c <= MAX_C);
    assign tgt_addr = tgt_c[ADDR_W-1:0];

    // RAM port steering: clear sweep owns the write port, otherwise the walk's
    // delayed write sets entry j when entry j-v read back as reachable.
    // Walk reads (j-v) always lie below every entry written in the same pass.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = (clr_reg == '0);
        end
        else
        begin
            ram_we    = wr_pend_reg && ram_rdata;
            ram_waddr = wr_addr_reg;
            ram_wdata = 1'b1;
        end
        if (state_reg == ST_WALK)
        begin
            ram_raddr = j_reg - v_reg;
        end
        else
        begin
            ram_raddr = tgt_addr;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        j_next       = j_reg;
        v_next       = v_reg;
        tgt_next     = tgt_reg;
        last_next    = last_reg;
        cfg_tgt_next = cfg_we ? cfg_wdata : cfg_tgt_reg;
        wr_pend_next = (state_reg == ST_WALK);
        wr_addr_next = j_reg;
        done_next    = 1'b0;
        found_next   = found_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MAX_A)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next    = element_value[ADDR_W-1:0];
                    tgt_next  = cfg_tgt_reg;
                    last_next = set_end;
                    j_next    = MAX_A;
                    if (has_element && !elem_skip)
                    begin
                        state_next = ST_WALK;
                    end
                    else if (set_end)
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_WALK:
            begin
                j_next = j_reg - 1'b1;
                if (j_reg == v_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_LOOKUP : ST_IDLE;
            end
            ST_LOOKUP:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                done_next  = 1'b1;
                found_next = ram_rdata && tgt_ok;
                clr_next   = '0;
                state_next = ST_CLEAR;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            j_reg       <= '0;
            v_reg       <= '0;
            tgt_reg     <= '0;
            cfg_tgt_reg <= '0;
            last_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
            wr_addr_reg <= '0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            j_reg       <= j_next;
            v_reg       <= v_next;
            tgt_reg     <= tgt_next;
            cfg_tgt_reg <= cfg_tgt_next;
            last_reg    <= last_next;
            wr_pend_reg <= wr_pend_next;
            wr_addr_reg <= wr_addr_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign subset_found = found_reg;
endmodule
`default_nettype wire
